// ----- rtl/core/psa_pkg.sv -----
// Shared constants and types for the parabolic sine approximation core.
`default_nettype none

package psa_pkg;

   localparam int FIELD_W = 24;
   localparam int Q_FRAC  = 30;

   // Q30 constants
   localparam logic [32:0] Q_TWO_PI          = 33'd6746518855;
   localparam logic [31:0] Q_PI              = 32'd3373259422;
   localparam logic [30:0] Q_FOUR_OVER_PI    = 31'd1367130546;
   localparam logic [28:0] Q_FOUR_OVER_PI_SQ = 29'd435171171;
   localparam logic [28:0] Q_REFINE          = 29'd273804165;
   localparam logic [30:0] Q_ONE             = 31'h4000_0000;

   // reduced angle, value and product widths
   localparam int XR_W = 34;
   localparam int VW   = 32;

   typedef struct packed {
      logic neg;
   } psa_side_type;

endpackage

`default_nettype wire

// ----- rtl/core/psa_wrap_stage.sv -----
// One restoring compare-subtract step of the 2*pi range reduction.
`default_nettype none

module psa_wrap_stage #(
   parameter int RW = 34,
   parameter logic [RW-1:0] STEP = '0
) (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [RW-1:0]         rem_in,
   input  wire psa_pkg::psa_side_type side_in,
   output logic      [RW-1:0]         rem_out,
   output psa_pkg::psa_side_type      side_out
);
   import psa_pkg::*;

   logic [RW-1:0] rem_ff;
   logic [RW-1:0] rem_in_d;
   psa_side_type  side_ff;

   assign rem_in_d = (rem_in >= STEP) ? rem_in - STEP : rem_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_d;
         side_ff <= side_in;
      end
   end

   assign rem_out  = rem_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

// ----- rtl/core/parabolic_sine_approx_core.sv -----
// The pipeline holds the 2*pi reduction, one quotient bit per stage, plus
// thirteen stages for widening, magnitude, fixup, the four multiplies and
// clamping.
// Throughput: one request per clock; each stage holds only while the next one is full.
// Reset: synchronous, clears all stage valid bits; data registers are not reset.
`default_nettype none

module parabolic_sine_approx_core #(
   parameter int ANGLE_FRAC_BITS = 20,
   parameter int OUT_FRAC_BITS   = 22
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] angle
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata    // [23:0] sine
);
   import psa_pkg::*;

   localparam int SH   = Q_FRAC - ANGLE_FRAC_BITS;
   localparam int OSH  = Q_FRAC - OUT_FRAC_BITS;
   localparam int WW   = (55 - ANGLE_FRAC_BITS > 35) ? 55 - ANGLE_FRAC_BITS : 35;
   localparam int RW   = WW - 1;
   localparam int QB   = (ANGLE_FRAC_BITS < 21) ? 22 - ANGLE_FRAC_BITS : 1;
   localparam int IFIX = 2 + QB;
   localparam int N    = IFIX + 11;
   localparam int PW   = XR_W + VW;
   localparam int QW   = VW + 31;
   localparam int ZW   = 2 * VW;

   logic [N-1:0] v_ff;
   logic [N-1:0] en;

   // stage enables: a stage moves when it is empty or its successor moves
   always_comb begin
      en[N-1] = !v_ff[N-1] || rsp_tready;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < N; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[N-1];

   // stage A: widen to Q30 and form pi - x
   logic signed [WW-1:0] ang_ext;
   logic signed [WW-1:0] w_in, w_ff;

   assign ang_ext = WW'(signed'(req_tdata[FIELD_W-1:0]));
   assign w_in    = signed'(WW'(Q_PI)) - (ang_ext <<< SH);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         w_ff <= w_in;
      end
   end

   // stage B: magnitude for the unsigned remainder steps
   logic [RW-1:0] mag_ff;
   psa_side_type  side_b_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mag_ff        <= w_ff[WW-1] ? RW'(-w_ff) : RW'(w_ff);
         side_b_ff.neg <= w_ff[WW-1];
      end
   end

   // remainder of |pi - x| by 2*pi, one quotient bit per stage
   logic [RW-1:0] div_rem  [QB];
   psa_side_type  div_side [QB];

   for (genvar k = 0; k < QB; k++) begin : g_wrap
      localparam logic [RW-1:0] STEP_K = RW'(Q_TWO_PI) << (QB - 1 - k);
      if (k == 0) begin : g_first
         psa_wrap_stage #(.RW(RW), .STEP(STEP_K)) u_stage (
            .clock    (clock),
            .enable   (en[2+k]),
            .rem_in   (mag_ff),
            .side_in  (side_b_ff),
            .rem_out  (div_rem[k]),
            .side_out (div_side[k])
         );
      end else begin : g_next
         psa_wrap_stage #(.RW(RW), .STEP(STEP_K)) u_stage (
            .clock    (clock),
            .enable   (en[2+k]),
            .rem_in   (div_rem[k-1]),
            .side_in  (div_side[k-1]),
            .rem_out  (div_rem[k]),
            .side_out (div_side[k])
         );
      end
   end

   // fixup: x = pi - ((pi - x) mod 2pi), which lands in (pi - 2pi, pi]
   logic [32:0]             m_rem;
   logic signed [XR_W-1:0]  m_s, pi_s, tpi_s, xr_in;
   psa_side_type            side_l;

   assign m_rem  = div_rem[QB-1][32:0];
   assign side_l = div_side[QB-1];
   assign m_s    = signed'(XR_W'(m_rem));
   assign pi_s   = signed'(XR_W'(Q_PI));
   assign tpi_s  = signed'(XR_W'(Q_TWO_PI));

   always_comb begin
      if (side_l.neg) begin
         // pi - x below zero: its modulus is 2pi - m unless m is zero
         xr_in = (m_rem == '0) ? pi_s : m_s - tpi_s + pi_s;
      end else begin
         xr_in = pi_s - m_s;
      end
   end

   logic signed [XR_W-1:0] xr_ff, xr1_ff, xr2_ff, xr3_ff;
   logic [XR_W-2:0]        ax_ff;
   logic [61:0]            p1_ff;
   logic signed [VW-1:0]   t_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [VW-1:0]   y5_ff, y6_ff, y7_ff, y8_ff;
   logic signed [VW:0]     d_ff;
   logic signed [QW-1:0]   q_ff;
   logic signed [VW-1:0]   r_ff;
   logic signed [ZW-1:0]   zp_ff;
   logic [FIELD_W-1:0]     sine_ff;

   logic signed [XR_W-1:0] zc;
   logic signed [XR_W-1:0] z_raw;
   logic signed [XR_W-1:0] z_out;
   logic signed [XR_W-1:0] q_one_z;

   assign q_one_z = signed'(XR_W'(Q_ONE));
   assign z_raw   = signed'(zp_ff[Q_FRAC +: XR_W]);

   always_comb begin
      if (z_raw > q_one_z) begin
         zc = q_one_z;
      end else if (z_raw < -q_one_z) begin
         zc = -q_one_z;
      end else begin
         zc = z_raw;
      end
   end

   assign z_out = zc >>> OSH;

   always_ff @(posedge clock) begin
      if (en[IFIX]) begin
         xr_ff <= xr_in;
      end
      if (en[IFIX+1]) begin
         xr1_ff <= xr_ff;
         ax_ff  <= (XR_W-1)'(xr_ff[XR_W-1] ? -xr_ff : xr_ff);
      end
      if (en[IFIX+2]) begin
         xr2_ff <= xr1_ff;
         p1_ff  <= 62'(Q_FOUR_OVER_PI_SQ) * 62'(ax_ff);
      end
      if (en[IFIX+3]) begin
         xr3_ff <= xr2_ff;
         t_ff   <= signed'(VW'(Q_FOUR_OVER_PI) - p1_ff[61:Q_FRAC]);
      end
      if (en[IFIX+4]) begin
         prod_ff <= PW'(xr3_ff) * PW'(t_ff);
      end
      if (en[IFIX+5]) begin
         y5_ff <= signed'(prod_ff[Q_FRAC +: VW]);
      end
      if (en[IFIX+6]) begin
         y6_ff <= y5_ff;
         d_ff  <= (y5_ff[VW-1] ? -((VW+1)'(y5_ff)) : (VW+1)'(y5_ff))
                  - signed'((VW+1)'(Q_ONE));
      end
      if (en[IFIX+7]) begin
         y7_ff <= y6_ff;
         q_ff  <= signed'(QW'(Q_REFINE)) * QW'(d_ff);
      end
      if (en[IFIX+8]) begin
         y8_ff <= y7_ff;
         r_ff  <= signed'(q_ff[Q_FRAC +: VW]) + signed'(VW'(Q_ONE));
      end
      if (en[IFIX+9]) begin
         zp_ff <= ZW'(y8_ff) * ZW'(r_ff);
      end
      if (en[IFIX+10]) begin
         sine_ff <= z_out[FIELD_W-1:0];
      end
   end

   assign rsp_tdata = sine_ff;

endmodule

`default_nettype wire

// ----- rtl/core/psa_checker.sv -----
// Port-level checks for the parabolic sine approximation core, with its bind.
`default_nettype none

module psa_checker #(
   parameter int OUT_FRAC_BITS = 22
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   localparam int ONE_OUT = (OUT_FRAC_BITS <= 22) ? (1 << OUT_FRAC_BITS) : 0;

   // a waiting request keeps its value
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request changed while stalled");

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // with the output stage empty, every stage can move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty pipeline");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (OUT_FRAC_BITS <= 22) |->
         ($signed(rsp_tdata) <= ONE_OUT) && ($signed(rsp_tdata) >= -ONE_OUT))
      else $error("sine outside plus or minus one");

endmodule

bind parabolic_sine_approx_core psa_checker #(
   .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_psa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- test/tb_parabolic_sine_approx_core.sv -----
// Testbench for parabolic_sine_approx_core: directed and randomized angle streams checked against a predictor.
`default_nettype none

class sine_scoreboard;
   localparam int ANGLE_FRAC = 20;
   localparam int OUT_FRAC   = 22;

   logic [23:0] expected_sines[$];
   int          failures;
   int          angles_seen;
   int          sines_checked;

   function new();
      failures      = 0;
      angles_seen   = 0;
      sines_checked = 0;
   endfunction

   // Q30 evaluation with floor-truncating products
   function logic [23:0] predict_sine(input logic signed [23:0] angle);
      longint qpi, q2pi, q4pi, q4pi2, qref, qone;
      longint x, ax, t, y, ay, r, z;
      qpi   = longint'(psa_pkg::Q_PI);
      q2pi  = longint'(psa_pkg::Q_TWO_PI);
      q4pi  = longint'(psa_pkg::Q_FOUR_OVER_PI);
      q4pi2 = longint'(psa_pkg::Q_FOUR_OVER_PI_SQ);
      qref  = longint'(psa_pkg::Q_REFINE);
      qone  = longint'(psa_pkg::Q_ONE);
      x = longint'(angle) <<< (psa_pkg::Q_FRAC - ANGLE_FRAC);
      while (x < -qpi) x = x + q2pi;
      while (x > qpi)  x = x - q2pi;
      ax = (x < 0) ? -x : x;
      t  = q4pi - ((q4pi2 * ax) >>> psa_pkg::Q_FRAC);
      y  = (x * t) >>> psa_pkg::Q_FRAC;
      ay = (y < 0) ? -y : y;
      r  = ((qref * (ay - qone)) >>> psa_pkg::Q_FRAC) + qone;
      z  = (y * r) >>> psa_pkg::Q_FRAC;
      if (z > qone)  z = qone;
      if (z < -qone) z = -qone;
      predict_sine = 24'(z >>> (psa_pkg::Q_FRAC - OUT_FRAC));
   endfunction

   function void note_angle(input logic [23:0] angle);
      expected_sines.push_back(predict_sine(angle));
      angles_seen++;
   endfunction

   function void check_sine(input logic [23:0] sine);
      logic [23:0] want;
      if (expected_sines.size() == 0) begin
         $error("sine: unexpected result, actual %0d (0x%06h)", $signed(sine), sine);
         failures++;
      end else begin
         want = expected_sines.pop_front();
         sines_checked++;
         if (want !== sine) begin
            $error("sine mismatch: expected %0d (0x%06h) actual %0d (0x%06h)",
                   $signed(want), want, $signed(sine), sine);
            failures++;
         end
      end
   endfunction

   function int pending();
      return expected_sines.size();
   endfunction
endclass

module tb_parabolic_sine_approx_core;
   localparam int ANGLE_FRAC_BITS = 20;
   localparam int OUT_FRAC_BITS   = 22;
   localparam int RANDOM_ANGLES   = 800;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   sine_scoreboard sb;
   bit tx_idle_on;
   bit rx_idle_on;
   int directed_count;

   parabolic_sine_approx_core #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS  (OUT_FRAC_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // mostly short, now and then long
   function int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75)      gap_len = $urandom_range(1, 3);
      else if (roll < 95) gap_len = $urandom_range(4, 10);
      else                gap_len = $urandom_range(20, 60);
   endfunction

   task automatic send_angle(input logic [23:0] angle);
      int gap;
      gap = 0;
      if (tx_idle_on && $urandom_range(0, 99) < 30) gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = angle;
      do @(posedge clock); while (!req_tready);
   endtask

   // angles near the quarter-turn points, where clamping and wrap decisions sit
   function logic [23:0] near_landmark();
      int marks[9];
      int off;
      marks = '{0, 1647099, -1647099, 3294199, -3294199, 4941298, -4941298,
                6588397, -6588397};
      off = int'($urandom_range(0, 64)) - 32;
      near_landmark = 24'(marks[$urandom_range(0, 8)] + off);
   endfunction

   // scoreboard taps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_angle(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_sine(rsp_tdata);
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      int cycles;
      stall  = 0;
      cycles = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         cycles++;
         if (cycles % 200 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
            rsp_tready = 1'b0;
            stall = gap_len() - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      logic signed [23:0] directed[$];
      logic [23:0] angle;
      sb = new();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // field extremes, quarter points, the +-pi and +-2pi wrap boundaries
      directed = '{24'sd0, 24'sd1, -24'sd1, 24'sd8388607, -24'sd8388608, 24'sd8388606,
                   24'sd1647099, 24'sd1647100, -24'sd1647099, -24'sd1647100,
                   24'sd3294198, 24'sd3294199, -24'sd3294198, -24'sd3294199,
                   24'sd4941298, -24'sd4941298, 24'sd6588397, 24'sd6588398,
                   -24'sd6588397, 24'sd1048576, -24'sd1048576, 24'sd524288,
                   24'sh555555, 24'shaaaaaa};
      directed_count = directed.size();
      foreach (directed[i]) send_angle(directed[i]);

      for (int n = 0; n < RANDOM_ANGLES; n++) begin
         if (n % 50 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 99) < 60) angle = 24'($urandom);
         else                           angle = near_landmark();
         send_angle(angle);
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Drove %0d angles (%0d directed, rest random over full range and near wrap points),",
               sb.angles_seen, directed_count);
      $display("checked %0d sine results with random gaps and back-pressure.", sb.sines_checked);
      if (sb.failures == 0) begin
         $display("tb_parabolic_sine_approx_core: PASS");
      end else begin
         $display("tb_parabolic_sine_approx_core: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d results outstanding.", sb.pending());
      $display("tb_parabolic_sine_approx_core: FAIL");
      $finish;
   end
endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/psa_pkg.sv
rtl/core/psa_wrap_stage.sv
rtl/core/parabolic_sine_approx_core.sv
rtl/core/psa_checker.sv
test/tb_parabolic_sine_approx_core.sv
